// File: hdl/pba_pkg.sv
package pba_pkg;

  localparam int NUM_PAGES   = 32768;
  localparam int WORD_BITS   = 64;
  localparam int MAP_WORDS   = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int PAGE_SHIFT  = 12;

  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int WADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PCNT_W      = $clog2(NUM_PAGES + 1);

  localparam int CMD_W       = 2;
  localparam int START_W     = 32;
  localparam int LEN_W       = 32;
  localparam int FIRST_W     = START_W - PAGE_SHIFT;
  localparam int ADDR_W      = 27;
  localparam int CNT_W       = 16;
  localparam int ADDR_FULL_W = WADDR_W + BIT_W + PAGE_SHIFT;

  localparam int IN_FIELDS_W  = START_W + LEN_W + 1;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + ADDR_W + CNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_FILL_ALL = 2'd0,
    CMD_REGION   = 2'd1,
    CMD_ALLOC    = 2'd2,
    CMD_COUNT    = 2'd3
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic fill;
    logic wr_region;
    logic wr_alloc;
    logic acc;
    logic inc;
    logic publish;
  } pba_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e op;
    logic empty;
    logic last;
    logic hit;
  } pba_stat_t;

  // SWAR bit count, one level per bit of the index
  function automatic logic [BIT_W:0] popcount(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] x;
    logic [WORD_BITS-1:0] m;
    x = w;
    for (int l = 0; l < BIT_W; l++) begin
      m = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
        if (((b >> l) & 1) == 0) m[b] = 1'b1;
      end
      x = (x & m) + ((x >> (1 << l)) & m);
    end
    return x[BIT_W:0];
  endfunction

  // encode a one-hot word into its bit position
  function automatic logic [BIT_W-1:0] onehot_index(input logic [WORD_BITS-1:0] iso);
    logic [BIT_W-1:0] idx;
    logic             acc;
    idx = '0;
    for (int k = 0; k < BIT_W; k++) begin
      acc = 1'b0;
      for (int b = 0; b < WORD_BITS; b++) begin
        if (((b >> k) & 1) == 1) acc = acc | iso[b];
      end
      idx[k] = acc;
    end
    return idx;
  endfunction

endpackage

// File: hdl/pba_dpath.sv
module pba_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pba_pkg::pba_cmd_t           cmd_i,
  output pba_pkg::pba_stat_t          stat_o,
  input  pba_pkg::cmd_e               command_i,
  input  logic [pba_pkg::START_W-1:0] start_address_i,
  input  logic [pba_pkg::LEN_W-1:0]   region_length_i,
  input  logic                        mark_used_i,
  output logic                        found_o,
  output logic [pba_pkg::ADDR_W-1:0]  block_address_o,
  output logic [pba_pkg::CNT_W-1:0]   free_count_o
);
  import pba_pkg::*;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_q;

  logic [WADDR_W-1:0]   wa_q, wa_d;
  logic [WADDR_W-1:0]   last_q, last_d;
  logic [WADDR_W-1:0]   first_word_q;
  logic [BIT_W-1:0]     first_bit_q;
  logic [BIT_W-1:0]     last_bit_q;
  cmd_e                 op_q;
  logic                 used_q;
  logic                 empty_q;

  logic                 found_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [CNT_W-1:0]     count_q;
  logic                 out_found_q;
  logic [ADDR_W-1:0]    out_addr_q;
  logic [CNT_W-1:0]     out_count_q;

  // region decode at load
  logic [FIRST_W-1:0]   first_full;
  logic [FIRST_W:0]     pages;
  logic [FIRST_W:0]     end_full;
  logic                 empty;
  logic [PCNT_W-1:0]    end_clip;
  logic [PCNT_W-1:0]    end_m1;
  logic [PCNT_W-1:0]    first_page;

  always_comb begin
    first_full = start_address_i[START_W-1:PAGE_SHIFT];
    pages      = (FIRST_W+1)'(region_length_i[LEN_W-1:PAGE_SHIFT]) + 1'b1;
    end_full   = (FIRST_W+1)'(first_full) + pages;
    empty      = (FIRST_W+1)'(first_full) >= (FIRST_W+1)'(NUM_PAGES);
    end_clip   = (end_full > (FIRST_W+1)'(NUM_PAGES)) ? PCNT_W'(NUM_PAGES)
                                                      : PCNT_W'(end_full);
    end_m1     = end_clip - 1'b1;
    first_page = PCNT_W'(first_full);
  end

  // word processing
  logic [WORD_BITS-1:0] inv;
  logic [WORD_BITS-1:0] iso;
  logic [BIT_W-1:0]     idx;
  logic [BIT_W-1:0]     lo_bit;
  logic [BIT_W-1:0]     hi_bit;
  logic [WORD_BITS-1:0] rmask;
  logic [WORD_BITS-1:0] region_word;
  logic [WORD_BITS-1:0] wdata;
  logic                 wr_en;
  logic [BIT_W:0]       pop;
  logic [CNT_W:0]       sum;
  logic [ADDR_FULL_W-1:0] addr_full;

  always_comb begin
    inv    = ~rdata_q;
    iso    = inv & (~inv + 1'b1);
    idx    = onehot_index(iso);
    lo_bit = (wa_q == first_word_q) ? first_bit_q : '0;
    hi_bit = (wa_q == last_q) ? last_bit_q : '1;
    for (int b = 0; b < WORD_BITS; b++) begin
      rmask[b] = (BIT_W'(b) >= lo_bit) && (BIT_W'(b) <= hi_bit);
    end
    region_word = used_q ? (rdata_q | rmask) : (rdata_q & ~rmask);
    if (cmd_i.fill) begin
      wdata = '1;
    end else if (cmd_i.wr_region) begin
      wdata = region_word;
    end else begin
      wdata = rdata_q | iso;
    end
    wr_en     = cmd_i.fill | cmd_i.wr_region | cmd_i.wr_alloc;
    pop       = popcount(inv);
    sum       = (CNT_W+1)'(count_q) + (CNT_W+1)'(pop);
    addr_full = ADDR_FULL_W'({wa_q, idx}) << PAGE_SHIFT;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wa_q] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[wa_q];
    end
  end

  always_comb begin
    wa_d   = wa_q;
    last_d = last_q;
    if (cmd_i.load) begin
      if (command_i == CMD_REGION) begin
        wa_d   = WADDR_W'(first_page >> BIT_W);
        last_d = WADDR_W'(end_m1 >> BIT_W);
      end else begin
        wa_d   = '0;
        last_d = WADDR_W'(MAP_WORDS - 1);
      end
    end else if (cmd_i.inc) begin
      wa_d = wa_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wa_q   <= '0;
      last_q <= WADDR_W'(MAP_WORDS - 1);
      op_q   <= CMD_FILL_ALL;
    end else begin
      wa_q   <= wa_d;
      last_q <= last_d;
      if (cmd_i.load) op_q <= command_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      used_q       <= mark_used_i;
      empty_q      <= empty;
      first_word_q <= WADDR_W'(first_page >> BIT_W);
      first_bit_q  <= first_page[BIT_W-1:0];
      last_bit_q   <= end_m1[BIT_W-1:0];
      found_q      <= 1'b0;
      addr_q       <= '0;
      count_q      <= '0;
    end else begin
      if (cmd_i.wr_alloc) begin
        found_q <= 1'b1;
        addr_q  <= ADDR_W'(addr_full);
      end
      if (cmd_i.acc) begin
        count_q <= sum[CNT_W] ? '1 : sum[CNT_W-1:0];
      end
    end
    if (cmd_i.publish) begin
      out_found_q <= found_q;
      out_addr_q  <= addr_q;
      out_count_q <= count_q;
    end
  end

  assign stat_o.op    = op_q;
  assign stat_o.empty = empty_q;
  assign stat_o.last  = (wa_q == last_q);
  assign stat_o.hit   = |inv;

  assign found_o         = out_found_q;
  assign block_address_o = out_addr_q;
  assign free_count_o    = out_count_q;

endmodule

// File: hdl/pba_ctrl.sv
module pba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  input  pba_pkg::pba_stat_t stat_i,
  output pba_pkg::pba_cmd_t  cmd_o
);
  import pba_pkg::*;

  typedef enum logic [2:0] {
    ST_FILL_RST,
    ST_IDLE,
    ST_RD,
    ST_EX,
    ST_FILL_CMD,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q & ~m_ready_i;
    case (state_q)
      ST_FILL_RST: begin
        cmd_o.fill = 1'b1;
        cmd_o.inc  = 1'b1;
        if (stat_i.last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RD;
        end
      end
      ST_RD: begin
        if (stat_i.op == CMD_FILL_ALL) begin
          state_d = ST_FILL_CMD;
        end else if (stat_i.op == CMD_REGION && stat_i.empty) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ST_EX;
        end
      end
      ST_EX: begin
        case (stat_i.op)
          CMD_REGION: begin
            cmd_o.wr_region = 1'b1;
            if (stat_i.last) begin
              state_d = ST_FIN;
            end else begin
              cmd_o.inc = 1'b1;
              state_d   = ST_RD;
            end
          end
          CMD_ALLOC: begin
            if (stat_i.hit) begin
              cmd_o.wr_alloc = 1'b1;
              state_d        = ST_FIN;
            end else if (stat_i.last) begin
              state_d = ST_FIN;
            end else begin
              cmd_o.inc = 1'b1;
              state_d   = ST_RD;
            end
          end
          CMD_COUNT: begin
            cmd_o.acc = 1'b1;
            if (stat_i.last) begin
              state_d = ST_FIN;
            end else begin
              cmd_o.inc = 1'b1;
              state_d   = ST_RD;
            end
          end
          default: begin
            state_d = ST_FIN;
          end
        endcase
      end
      ST_FILL_CMD: begin
        cmd_o.fill = 1'b1;
        cmd_o.inc  = 1'b1;
        if (stat_i.last) state_d = ST_FIN;
      end
      ST_FIN: begin
        // hold the result until the output register is free
        if (!out_valid_q || m_ready_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;

endmodule

// File: hdl/page_bitmap_allocator.sv
// From the accepting edge to tvalid: mark all used writes each map word in turn;
// mark region reads and rewrites each map word touched, or skips to the result if
// it starts beyond the map; allocate reads up to the first word with a free page;
// count free pages reads every word. A result waits while the previous one is held.
// Throughput: one command at a time, tready returns in the same cycle that tvalid rises.
// Reset: the bitmap is swept word by word to all used with tready low.
module page_bitmap_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // start_address, region_length, mark_used, zero pad
  input  logic [pba_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // command
  input  logic [pba_pkg::CMD_W-1:0]      s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // found, block_address, free_count, zero pad
  output logic [pba_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import pba_pkg::*;

  pba_cmd_t          cmd;
  pba_stat_t         stat;
  logic              found;
  logic [ADDR_W-1:0] block_address;
  logic [CNT_W-1:0]  free_count;

  pba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  pba_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .command_i       (cmd_e'(s_axis_tuser)),
    .start_address_i (s_axis_tdata[START_W-1:0]),
    .region_length_i (s_axis_tdata[START_W+LEN_W-1:START_W]),
    .mark_used_i     (s_axis_tdata[START_W+LEN_W]),
    .found_o         (found),
    .block_address_o (block_address),
    .free_count_o    (free_count)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, free_count, block_address, found};

  // one command in flight: an accepted transaction closes the input side
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a command is in progress");

  a_addr_zero_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !found) |-> (block_address == '0))
    else $error("nonzero address without a found page");

  a_count_excludes_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (free_count != '0)) |-> !found)
    else $error("count and allocation reported together");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (int'(free_count) <= NUM_PAGES))
    else $error("free count beyond the map size");

endmodule
